// File: rtl/core/qau_pkg.sv
`default_nettype none

package qau_pkg;

   // word format, signed fixed point
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAG_BITS  = WORD_BITS - 1;
   localparam int TOL_BITS  = 16;

   // pipeline depths of the shared units
   localparam int SQRT_STAGES = WORD_BITS;
   localparam int DIV_LAT     = WORD_BITS + 2;
   localparam int MUL_LAT     = 2;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef word_type [3:0] quat_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      MODE_MUL   = 3'd0,
      MODE_CONJ  = 3'd1,
      MODE_SCALE = 3'd2,
      MODE_NORM  = 3'd3,
      MODE_INV   = 3'd4,
      MODE_DIFF  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0] mode;
      word_type   a_r;
      word_type   a_i;
      word_type   a_j;
      word_type   a_k;
      word_type   b_r;
      word_type   b_i;
      word_type   b_j;
      word_type   b_k;
      word_type   scale_factor;
   } req_type;

   typedef struct packed {
      word_type              out_r;
      word_type              out_i;
      word_type              out_j;
      word_type              out_k;
      logic [MAG_BITS-1:0]   magnitude;
      logic                  is_unit;
      logic                  overflow;
   } rsp_type;

   // request data that travels beside the arithmetic units
   typedef struct packed {
      logic [2:0]              mode;
      quat_type                a;
      quat_type                b;
      word_type                scale;
      logic [2*WORD_BITS-1:0]  sum;
      logic                    zero;
      logic                    big;
      logic [MAG_BITS-1:0]     magnitude;
      logic                    is_unit;
   } side_type;

   // saturated word with its overflow flag
   typedef struct packed {
      word_type q;
      logic     ovf;
   } qres_type;

endpackage

`default_nettype wire

// File: rtl/core/quaternion_arithmetic_unit.sv
`default_nettype none

// Quaternion arithmetic unit, signed Q16.16.
// A request is taken at a rising edge with start high and busy low. busy is
// always low: the pipeline takes one request per cycle, every cycle.
// req_data carries mode, quaternions a and b and the scale factor.
// The result shows on rsp_data for exactly one cycle with rsp_valid high,
// after its request has passed through squaring and summing, the square
// root (one root bit per stage), division (entry, one quotient bit per
// stage, saturation) and the product array and combine.
// Results leave in request order.
// Every mode passes through all stages, so latency does not depend on mode.
// The receiver cannot stall; nothing is held back.
// csr_write_en with csr_write_data sets the unit tolerance; write it only
// while no request is in flight.
// Synchronous reset empties the pipeline and sets the tolerance to 1 LSB.
module quaternion_arithmetic_unit import qau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [TOL_BITS-1:0]  csr_write_data
);

   localparam int NW = 2 * WORD_BITS;
   localparam logic [WORD_BITS-1:0] UNIT_ONE = WORD_BITS'(1) << FRAC_BITS;

   logic [TOL_BITS-1:0] tol_ff;
   logic [3:0]          stg_valid_ff;
   req_type             in_ff;
   quat_type            a_q;
   quat_type            b_q;
   logic [NW-1:0]       sq_ff   [4];
   logic [NW:0]         pair_ff [2];
   side_type            side2_ff;
   side_type            side2_in;
   side_type            side3_ff;
   side_type            side4_ff;
   side_type            side4_in;
   side_type            dly1_ff [SQRT_STAGES];
   side_type            dly2_ff [DIV_LAT];
   side_type            side5;
   logic                sqrt_valid;
   logic [WORD_BITS-1:0] root;
   logic [NW-1:0]       div_num [4];
   logic [NW-1:0]       div_den;
   logic [3:0]          div_neg;
   logic [3:0]          div_valid;
   qres_type            div_res [4];
   quat_type            quot;
   logic                quot_ovf;

   assign busy = 1'b0;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_BITS'(1);
      end else if (csr_write_en) begin
         tol_ff <= csr_write_data;
      end
   end

   // front stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         stg_valid_ff <= {stg_valid_ff[2:0], start & ~busy};
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_ff <= req_data;
      end
   end

   assign a_q = {in_ff.a_k, in_ff.a_j, in_ff.a_i, in_ff.a_r};
   assign b_q = {in_ff.b_k, in_ff.b_j, in_ff.b_i, in_ff.b_r};

   // request fields that follow the squares
   always_comb begin
      side2_in       = '0;
      side2_in.mode  = in_ff.mode;
      side2_in.a     = a_q;
      side2_in.b     = b_q;
      side2_in.scale = in_ff.scale_factor;
   end

   // squares of a, then a two level adder tree
   always_ff @(posedge clock) begin
      for (int n = 0; n < 4; n++) begin
         sq_ff[n] <= $signed(a_q[n]) * $signed(a_q[n]);
      end
      side2_ff           <= side2_in;
      pair_ff[0]         <= {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      pair_ff[1]         <= {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
      side3_ff           <= side2_ff;
      side4_ff           <= side4_in;
   end

   // full sum of squares; it reaches 2^64 only for the most negative a
   always_comb begin
      logic [NW+1:0] total;
      total          = {1'b0, pair_ff[0]} + {1'b0, pair_ff[1]};
      side4_in       = side3_ff;
      side4_in.sum   = total[NW-1:0];
      side4_in.big   = total[NW];
      side4_in.zero  = (total == '0);
   end

   qau_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid_ff[3]),
      .radicand  (side4_ff.sum),
      .out_valid (sqrt_valid),
      .root      (root)
   );

   // side data alongside the root pipeline and the divider
   always_ff @(posedge clock) begin
      dly1_ff[0] <= side4_ff;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         dly1_ff[i] <= dly1_ff[i-1];
      end
      dly2_ff[0] <= side5;
      for (int i = 1; i < DIV_LAT; i++) begin
         dly2_ff[i] <= dly2_ff[i-1];
      end
   end

   // magnitude, unit test and divider operands
   always_comb begin
      side_type             sx;
      logic [WORD_BITS-1:0] mag;
      logic [WORD_BITS-1:0] dev;
      logic [WORD_BITS-1:0] ux;
      logic                 norm;
      logic                 inv;
      logic                 div_en;
      sx   = dly1_ff[SQRT_STAGES-1];
      mag  = sx.big ? '1 : root;
      dev  = (mag > UNIT_ONE) ? (mag - UNIT_ONE) : (UNIT_ONE - mag);
      side5           = sx;
      side5.magnitude = mag[WORD_BITS-1] ? '1 : mag[MAG_BITS-1:0];
      side5.is_unit   = (dev < WORD_BITS'(tol_ff));
      norm   = (sx.mode == MODE_NORM);
      inv    = (sx.mode == MODE_INV) || (sx.mode == MODE_DIFF);
      div_en = !sx.zero && (norm || (inv && !sx.big));
      div_den = norm ? NW'(mag) : sx.sum;
      if (!div_en) begin
         div_den = NW'(1);
      end
      for (int n = 0; n < 4; n++) begin
         ux = sx.a[n][WORD_BITS-1] ? (~sx.a[n] + 1'b1) : sx.a[n];
         div_num[n] = norm ? (NW'(ux) << FRAC_BITS) : (NW'(ux) << (2 * FRAC_BITS));
         if (!div_en) begin
            div_num[n] = '0;
         end
         div_neg[n] = sx.a[n][WORD_BITS-1] ^ (inv && (n != 0));
      end
   end

   // four divider lanes, one per component
   for (genvar n = 0; n < 4; n++) begin : g_div
      qau_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sqrt_valid),
         .num       (div_num[n]),
         .den       (div_den),
         .neg_res   (div_neg[n]),
         .out_valid (div_valid[n]),
         .res       (div_res[n])
      );
      assign quot[n] = div_res[n].q;
   end

   assign quot_ovf = div_res[0].ovf | div_res[1].ovf | div_res[2].ovf | div_res[3].ovf;

   qau_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[0]),
      .side      (dly2_ff[DIV_LAT-1]),
      .quot      (quot),
      .quot_ovf  (quot_ovf),
      .out_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // the divider lanes run in lock step
   assert property (@(posedge clock) disable iff (reset)
      (div_valid[0] == div_valid[1]) && (div_valid[2] == div_valid[3])
      && (div_valid[0] == div_valid[2]))
      else $error("divider lanes out of step");

   // every result traces back to a root of the same request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(sqrt_valid, DIV_LAT + MUL_LAT))
      else $error("result strobe without a request behind it");

endmodule

`default_nettype wire

// File: rtl/core/qau_sqrt.sv
`default_nettype none

module qau_sqrt import qau_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [2*WORD_BITS-1:0]  radicand,
   output logic                    out_valid,
   output logic [WORD_BITS-1:0]    root
);

   localparam int RW = WORD_BITS + 2;
   localparam int NW = 2 * WORD_BITS;

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [RW-1:0]          rem_ff  [SQRT_STAGES];
   logic [WORD_BITS-1:0]   root_ff [SQRT_STAGES];
   logic [NW-1:0]          rest_ff [SQRT_STAGES];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQRT_STAGES-2:0], in_valid};
      end
   end

   // one root bit per stage, two radicand bits brought down each time
   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic [RW-1:0]        rem_prev;
      logic [RW-1:0]        rem_shift;
      logic [RW-1:0]        trial;
      logic [RW-1:0]        rem_in;
      logic [WORD_BITS-1:0] root_prev;
      logic [WORD_BITS-1:0] root_in;
      logic [NW-1:0]        rest_prev;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rest_prev = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rest_prev = rest_ff[i-1];
      end

      always_comb begin
         rem_shift = {rem_prev[RW-3:0], rest_prev[NW-1 -: 2]};
         trial     = {root_prev, 2'b01};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_prev[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_prev[WORD_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         rest_ff[i] <= {rest_prev[NW-3:0], 2'b00};
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign root      = root_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/qau_div.sv
`default_nettype none

module qau_div import qau_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [2*WORD_BITS-1:0]  num,
   input  logic [2*WORD_BITS-1:0]  den,
   input  logic                    neg_res,
   output logic                    out_valid,
   output qres_type                res
);

   localparam int NW = 2 * WORD_BITS;
   localparam int CW = 3 * WORD_BITS;

   logic [WORD_BITS+1:0] valid_ff;
   logic [NW-1:0]        rem_ff [WORD_BITS+1];
   logic [NW-1:0]        den_ff [WORD_BITS+1];
   logic [WORD_BITS-1:0] quo_ff [WORD_BITS+1];
   logic                 neg_ff [WORD_BITS+1];
   logic                 hi_ff  [WORD_BITS+1];
   qres_type             res_ff;
   qres_type             res_in;

   // valid chain: entry, quotient bits, saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[WORD_BITS:0], in_valid};
      end
   end

   // entry: quotient of at least one full word means saturation
   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      neg_ff[0] <= neg_res;
      hi_ff[0]  <= ({{WORD_BITS{1'b0}}, num[NW-1:WORD_BITS]} >= den);
   end

   // restoring division, quotient msb first
   for (genvar k = 1; k <= WORD_BITS; k++) begin : g_stage
      logic [CW-1:0] shifted;
      logic          take;
      logic [NW-1:0] rem_in;

      always_comb begin
         shifted = CW'(den_ff[k-1]) << (WORD_BITS - k);
         take    = ({{WORD_BITS{1'b0}}, rem_ff[k-1]} >= shifted);
         rem_in  = take ? (rem_ff[k-1] - shifted[NW-1:0]) : rem_ff[k-1];
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= {quo_ff[k-1][WORD_BITS-2:0], take};
         neg_ff[k] <= neg_ff[k-1];
         hi_ff[k]  <= hi_ff[k-1];
      end
   end

   // saturate to the signed word and apply the sign
   always_comb begin
      logic [WORD_BITS:0] lim;
      logic [WORD_BITS:0] mag;
      lim = {2'b00, {(WORD_BITS-1){1'b1}}} + {{WORD_BITS{1'b0}}, neg_ff[WORD_BITS]};
      mag = {1'b0, quo_ff[WORD_BITS]};
      res_in.ovf = 1'b0;
      if (hi_ff[WORD_BITS] || (mag > lim)) begin
         res_in.ovf = 1'b1;
         mag        = lim;
      end
      res_in.q = neg_ff[WORD_BITS] ? -mag[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid = valid_ff[WORD_BITS+1];
   assign res       = res_ff;

   // a saturated quotient sits at one end of the word
   assert property (@(posedge clock) disable iff (reset)
      out_valid && res.ovf |-> (res.q == WORD_MAX) || (res.q == WORD_MIN))
      else $error("divider overflow without a saturated quotient");

   // fixed latency through the lane
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, DIV_LAT))
      else $error("divider result without a matching request");

endmodule

`default_nettype wire

// File: rtl/core/qau_mul.sv
`default_nettype none

module qau_mul import qau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  side_type  side,
   input  quat_type  quot,
   input  logic      quot_ovf,
   output logic      out_valid,
   output rsp_type   rsp
);

   localparam int PW    = 2 * WORD_BITS;
   localparam int ACC_W = 2 * WORD_BITS - FRAC_BITS + 2;

   function automatic qres_type sat_word(input logic signed [ACC_W-1:0] v);
      qres_type r;
      r.ovf = 1'b0;
      r.q   = v[WORD_BITS-1:0];
      if (v > ACC_W'(WORD_MAX)) begin
         r.ovf = 1'b1;
         r.q   = WORD_MAX;
      end else if (v < ACC_W'(WORD_MIN)) begin
         r.ovf = 1'b1;
         r.q   = WORD_MIN;
      end
      return r;
   endfunction

   quat_type                 x_op;
   quat_type                 y_op;
   logic signed [PW-1:0]     prod_ff [4][4];
   logic                     valid_a_ff;
   logic [2:0]               mode_ff;
   quat_type                 a_ff;
   quat_type                 t_ff;
   logic                     dov_ff;
   logic [MAG_BITS-1:0]      mag_ff;
   logic                     unit_ff;
   logic                     valid_b_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;

   // operand select: inverse feeds the difference, scalar feeds scaling
   always_comb begin
      x_op = (side.mode == MODE_DIFF) ? quot : side.a;
      for (int n = 0; n < 4; n++) begin
         y_op[n] = (side.mode == MODE_SCALE) ? side.scale : side.b[n];
      end
   end

   // product array
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_ff[i][j] <= $signed(x_op[i]) * $signed(y_op[j]);
         end
      end
      mode_ff <= side.mode;
      a_ff    <= side.a;
      t_ff    <= quot;
      dov_ff  <= quot_ovf;
      mag_ff  <= side.magnitude;
      unit_ff <= side.is_unit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   // select per mode: combined products, conjugate, scaled products or quotient, saturated
   always_comb begin
      logic signed [ACC_W-1:0] f [4][4];
      logic signed [ACC_W-1:0] h [4];
      qres_type                s [4];
      logic                    ov;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            f[i][j] = ACC_W'(prod_ff[i][j] >>> FRAC_BITS);
         end
      end
      h[0] = f[0][0] - f[1][1] - f[2][2] - f[3][3];
      h[1] = f[0][1] + f[1][0] + f[2][3] - f[3][2];
      h[2] = f[0][2] - f[1][3] + f[2][0] + f[3][1];
      h[3] = f[0][3] + f[1][2] - f[2][1] + f[3][0];
      for (int n = 0; n < 4; n++) begin
         s[n] = '0;
      end
      ov = 1'b0;
      case (mode_ff)
         MODE_MUL, MODE_DIFF: begin
            for (int n = 0; n < 4; n++) begin
               s[n] = sat_word(h[n]);
            end
            ov = dov_ff;
         end
         MODE_CONJ: begin
            s[0].q = a_ff[0];
            for (int n = 1; n < 4; n++) begin
               s[n] = sat_word(-(ACC_W'($signed(a_ff[n]))));
            end
         end
         MODE_SCALE: begin
            for (int n = 0; n < 4; n++) begin
               s[n] = sat_word(f[n][n]);
            end
         end
         MODE_NORM, MODE_INV: begin
            for (int n = 0; n < 4; n++) begin
               s[n].q = t_ff[n];
            end
            ov = dov_ff;
         end
         default: begin
            ov = 1'b0;
         end
      endcase
      rsp_in.out_r     = s[0].q;
      rsp_in.out_i     = s[1].q;
      rsp_in.out_j     = s[2].q;
      rsp_in.out_k     = s[3].q;
      rsp_in.magnitude = mag_ff;
      rsp_in.is_unit   = unit_ff;
      rsp_in.overflow  = ov | s[0].ovf | s[1].ovf | s[2].ovf | s[3].ovf;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_b_ff;
   assign rsp       = rsp_ff;

   // undefined modes give a zero result without overflow
   assert property (@(posedge clock) disable iff (reset)
      valid_a_ff && (mode_ff > MODE_DIFF) |=> out_valid && (rsp.out_r == '0) && !rsp.overflow)
      else $error("undefined mode produced a nonzero result");

endmodule

`default_nettype wire
